[design/fpisqrt_pkg.sv]
// package: widths, constants, item type and seed table for the inverse square root pipeline
package fpisqrt_pkg;

    localparam int Q_INT        = 3;
    localparam int Q_FRAC       = 8;
    localparam int LUT_BITS     = 5;
    localparam int NEWTON_STEPS = 1;

    localparam int W        = Q_INT + Q_FRAC;
    localparam int MSB_W    = $clog2(W);
    localparam int K_W      = MSB_W + 1;
    localparam int ROM_SIZE = 1 << LUT_BITS;
    localparam int SEED_W   = 16;
    localparam int FIN      = (W - 1) - Q_FRAC;
    localparam int SC_W     = W + 1 + Q_FRAC / 2;

    localparam logic [W-1:0]      ONE_Q      = W'(1) << (W - 1);
    localparam logic [W-1:0]      TH         = W'(3) << (W - 2);
    localparam logic [W-1:0]      MAX_OUT    = '1;
    localparam logic [SEED_W-1:0] SQRT2_Q15  = 16'hB504;
    localparam logic [SEED_W-1:0] ISQRT2_Q15 = 16'h5A82;

    // word moving through the pipeline
    typedef struct packed {
        logic [W-1:0]     y;
        logic [W-2:0]     half;
        logic [MSB_W-1:0] msb;
        logic             zero;
        logic             pow2;
    } t_item;

    typedef logic [ROM_SIZE-1:0][SEED_W-1:0] t_seed_rom;

    // seed i = floor(2^(W-1) / sqrt(1 + (i+1)/(ROM_SIZE+1))), exact bit search
    function automatic t_seed_rom build_rom();
        t_seed_rom        rom;
        longint unsigned  target;
        longint unsigned  den;
        longint unsigned  y;
        longint unsigned  t;
        target = (64'd1 << (2 * (W - 1))) * longint'(ROM_SIZE + 1);
        for (int i = 0; i < ROM_SIZE; i++) begin
            den = longint'(ROM_SIZE + 2 + i);
            y   = 0;
            for (int b = W - 1; b >= 0; b--) begin
                t = y | (64'd1 << b);
                if (t * t * den <= target) begin
                    y = t;
                end
            end
            rom[i] = y[SEED_W-1:0];
        end
        return rom;
    endfunction

    localparam t_seed_rom SEED_ROM = build_rom();

endpackage

[design/fpisqrt_newton.sv]
// one newton-raphson refinement step y = y*(1.5 - (m/2)*y*y), three register stages
module fpisqrt_newton
    import fpisqrt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    logic           r_a_valid, r_b_valid, r_c_valid;
    t_item          r_a_item, r_b_item, r_c_item;
    logic [W-1:0]   r_a_yy, r_b_diff;
    logic           en_a, en_b, en_c;

    logic [2*W-1:0] p_yy;
    logic [2*W-2:0] p_prod;
    logic [2*W-1:0] p_y;
    logic [W-1:0]   n_yy, n_prod, n_diff, n_y;
    t_item          n_c_item;

    assign en_c    = !r_c_valid || i_ready;
    assign en_b    = !r_b_valid || en_c;
    assign en_a    = !r_a_valid || en_b;
    assign o_ready = en_a;

    always_comb begin
        p_yy   = (2*W)'(i_item.y) * (2*W)'(i_item.y);
        n_yy   = p_yy[2*W-2:W-1];
        p_prod = (2*W-1)'(r_a_yy) * (2*W-1)'(r_a_item.half);
        n_prod = p_prod[2*W-2:W-1];
        n_diff = (n_prod > TH) ? '0 : TH - n_prod;
        p_y    = (2*W)'(r_b_item.y) * (2*W)'(r_b_diff);
        n_y    = p_y[2*W-2:W-1];
        n_c_item   = r_b_item;
        n_c_item.y = n_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (en_a) r_a_valid <= i_valid;
            if (en_b) r_b_valid <= r_a_valid;
            if (en_c) r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_item <= i_item;
            r_a_yy   <= n_yy;
        end
        if (en_b) begin
            r_b_item <= r_a_item;
            r_b_diff <= n_diff;
        end
        if (en_c) begin
            r_c_item <= n_c_item;
        end
    end

    assign o_valid = r_c_valid;
    assign o_item  = r_c_item;

endmodule

[design/fixed_point_inverse_sqrt.sv]
// top level: pipelined 1/sqrt(x) for unsigned Q3.8 operands, seed table plus newton steps
//
//  channel | valid   | ready   | data          | moves
//  --------+---------+---------+---------------+-------------------------------
//  in      | i_valid | o_ready | i_value_in    | one operand word per handshake
//  out     | o_valid | i_ready | o_inv_root    | one result word per operand
//
// one word per cycle sustained while i_ready does not stall the output
// stages: normalize, seed lookup, three per newton step (square, product, update),
// scale multiply, shift and saturate into the output register
// each stage holds its own valid bit and loads whenever it is empty or its
// successor moves, so a stall backs up stage by stage and fills bubbles
// synchronous active-low reset clears the valid bits only
module fixed_point_inverse_sqrt
    import fpisqrt_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [W-1:0]  i_value_in,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [W-1:0]  o_inv_root
);

    // stage 1: leading one and normalize
    logic             r_s1_valid;
    logic [W-1:0]     r_s1_mant;
    logic [MSB_W-1:0] r_s1_msb;
    logic             r_s1_zero;
    logic [MSB_W-1:0] n_msb;
    logic [W-1:0]     n_mant;
    logic             en_s1;

    // stage 2: seed lookup
    logic             r_s2_valid;
    t_item            r_s2_item;
    t_item            n_s2_item;
    logic [LUT_BITS-1:0] n_idx;
    logic [LUT_BITS-1:0] n_sel;
    logic [SEED_W-1:0]   n_seed;
    logic             en_s2;

    // newton chain
    logic             st_valid [NEWTON_STEPS+1];
    logic             st_ready [NEWTON_STEPS+1];
    t_item            st_item  [NEWTON_STEPS+1];

    // scale stage a: constant multiply
    logic             r_sa_valid;
    logic [W:0]       r_sa_base;
    logic signed [K_W-1:0] r_sa_k;
    logic             r_sa_zero;
    logic [W-1:0]     n_ysel;
    logic signed [K_W-1:0] n_k;
    logic [W+SEED_W-1:0]   p_scale;
    logic [W:0]       n_base;
    logic             en_sa;

    // output stage: shift and saturate
    logic             r_out_valid;
    logic [W-1:0]     r_inv_root;
    logic [K_W-1:0]   n_abs_k;
    logic [K_W-1:0]   n_sh;
    logic [SC_W-1:0]  n_wide;
    logic [SC_W-1:0]  n_res;
    logic [W-1:0]     n_root;
    logic             en_out;

    assign en_out   = !r_out_valid || i_ready;
    assign en_sa    = !r_sa_valid || en_out;
    assign st_ready[NEWTON_STEPS] = en_sa;
    assign en_s2    = !r_s2_valid || st_ready[0];
    assign en_s1    = !r_s1_valid || en_s2;
    assign o_ready  = en_s1;

    // priority encoder, highest set bit wins
    always_comb begin
        n_msb = '0;
        for (int b = 0; b < W; b++) begin
            if (i_value_in[b]) n_msb = MSB_W'(b);
        end
        n_mant = i_value_in << (MSB_W'(W - 1) - n_msb);
    end

    // seed: index 0 uses entry 0, index j uses entry j-1
    always_comb begin
        n_idx  = r_s1_mant[W-2 -: LUT_BITS];
        n_sel  = (n_idx == '0) ? '0 : n_idx - LUT_BITS'(1);
        n_seed = SEED_ROM[n_sel];
        n_s2_item.y    = n_seed[W-1:0];
        n_s2_item.half = r_s1_mant[W-1:1];
        n_s2_item.msb  = r_s1_msb;
        n_s2_item.zero = r_s1_zero;
        n_s2_item.pow2 = (r_s1_mant == ONE_Q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_sa_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en_s1)  r_s1_valid  <= i_valid;
            if (en_s2)  r_s2_valid  <= r_s1_valid;
            if (en_sa)  r_sa_valid  <= st_valid[NEWTON_STEPS];
            if (en_out) r_out_valid <= r_sa_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s1) begin
            r_s1_mant <= n_mant;
            r_s1_msb  <= n_msb;
            r_s1_zero <= (i_value_in == '0);
        end
        if (en_s2) begin
            r_s2_item <= n_s2_item;
        end
        if (en_sa) begin
            r_sa_base <= n_base;
            r_sa_k    <= n_k;
            r_sa_zero <= st_item[NEWTON_STEPS].zero;
        end
        if (en_out) begin
            r_inv_root <= n_root;
        end
    end

    assign st_valid[0] = r_s2_valid;
    assign st_item[0]  = r_s2_item;

    for (genvar s = 0; s < NEWTON_STEPS; s++) begin : g_newton
        fpisqrt_newton u_newton (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (st_valid[s]),
            .o_ready (st_ready[s]),
            .i_item  (st_item[s]),
            .o_valid (st_valid[s+1]),
            .i_ready (st_ready[s+1]),
            .o_item  (st_item[s+1])
        );
    end

    // k = frac - msb; odd k takes a sqrt2 (k > 0) or 1/sqrt2 (k < 0) factor
    always_comb begin
        n_ysel  = st_item[NEWTON_STEPS].pow2 ? ONE_Q : st_item[NEWTON_STEPS].y;
        n_k     = $signed(K_W'(Q_FRAC)) - $signed({1'b0, st_item[NEWTON_STEPS].msb});
        p_scale = (W+SEED_W)'(n_ysel)
                * (W+SEED_W)'((n_k > 0) ? SQRT2_Q15 : ISQRT2_Q15);
        n_base  = n_k[0] ? p_scale[W+15:15] : {1'b0, n_ysel};
    end

    // shift by |k|/2 either way, drop to the output fraction, saturate
    always_comb begin
        n_abs_k = (r_sa_k < 0) ? K_W'(-r_sa_k) : K_W'(r_sa_k);
        n_sh    = n_abs_k >> 1;
        if (r_sa_k > 0) begin
            n_wide = SC_W'(r_sa_base) << n_sh;
        end else begin
            n_wide = SC_W'(r_sa_base) >> n_sh;
        end
        n_res = n_wide >> FIN;
        if (r_sa_zero || (n_res > SC_W'(MAX_OUT))) begin
            n_root = MAX_OUT;
        end else begin
            n_root = n_res[W-1:0];
        end
    end

    assign o_valid    = r_out_valid;
    assign o_inv_root = r_inv_root;

endmodule
